// ===== hdl/iee_pkg.sv =====
// ----------------------------------------------------------------------------
// iee_pkg : shared types and constants for the infix expression evaluator
// Token codes, status codes, stack sizes and the fixed-point format.
// ----------------------------------------------------------------------------
package iee_pkg;

  localparam int unsigned ValueDepth    = 32;
  localparam int unsigned OperatorDepth = 32;
  localparam int unsigned FractionBits  = 32;
  localparam int unsigned ValueAw       = $clog2(ValueDepth);
  localparam int unsigned OperatorAw    = $clog2(OperatorDepth);
  localparam int unsigned ThresholdReset = 429;

  typedef enum logic [2:0] {
    CMD_NUM = 3'd0,
    CMD_LB  = 3'd1,
    CMD_RB  = 3'd2,
    CMD_ADD = 3'd3,
    CMD_SUB = 3'd4,
    CMD_MUL = 3'd5,
    CMD_DIV = 3'd6,
    CMD_END = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DIV0      = 3'd1,
    ST_UNMATCHED = 3'd2,
    ST_NOT_ONE   = 3'd3,
    ST_MISSING   = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_e;

  // request to the arithmetic unit
  typedef struct packed {
    logic        start;
    cmd_e        op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  // answer from the arithmetic unit
  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } alu_rsp_t;

endpackage

// ===== hdl/iee_if.sv =====
// ----------------------------------------------------------------------------
// iee_tok_if / iee_res_if : valid/ready channels of the evaluator
// Token channel in, result channel out.
// ----------------------------------------------------------------------------
interface iee_tok_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic signed [63:0] number_value;
  modport source (output valid, command, number_value, input ready);
  modport sink   (input valid, command, number_value, output ready);
endinterface

interface iee_res_if;
  logic        valid;
  logic        ready;
  logic signed [63:0] result_value;
  logic [2:0]  status;
  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

// ===== hdl/iee_alu.sv =====
// ----------------------------------------------------------------------------
// iee_alu : shared saturating arithmetic unit
// Add/sub answered straight from the idle state, multiply over four 32x32 partial products,
// divide as a restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module iee_alu import iee_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  localparam int unsigned DivSteps = 64 + FractionBits;
  localparam int unsigned CntW     = $clog2(DivSteps + 1);

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL  = 4'b0010,
    A_DIV  = 4'b0100,
    A_FIN  = 4'b1000
  } alu_state_e;

  alu_state_e     state_q, state_d;
  logic           neg_q, neg_d;
  logic [63:0]    x_q, x_d;         // magnitude of a, shifted out as numerator
  logic [63:0]    y_q, y_d;         // magnitude of b
  logic [64:0]    rem_q, rem_d;
  logic [127:0]   acc_q, acc_d;     // product / quotient
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [63:0]    res_q, res_d;
  logic           done_q, done_d;

  logic [63:0]    mag_a, mag_b, sum;
  logic [63:0]    pp;
  logic [31:0]    xs, ys;
  logic [64:0]    rem_sh;
  logic [63:0]    m_sat;
  logic           ovf_sat;

  assign mag_a = req_i.a[63] ? (~req_i.a + 64'd1) : req_i.a;
  assign mag_b = req_i.b[63] ? (~req_i.b + 64'd1) : req_i.b;

  // one 32x32 partial product per multiply step
  always_comb begin
    xs = cnt_q[0] ? x_q[63:32] : x_q[31:0];
    ys = cnt_q[1] ? y_q[63:32] : y_q[31:0];
  end
  assign pp = 64'(xs) * 64'(ys);

  // divider shift-subtract step
  assign rem_sh = {rem_q[63:0], x_q[63]};

  // product magnitude above the fraction bits and its overflow flag
  always_comb begin
    if (FractionBits == 0) begin
      m_sat   = acc_q[63:0];
      ovf_sat = |acc_q[127:64];
    end else begin
      m_sat   = acc_q[FractionBits +: 64];
      ovf_sat = |(acc_q[127:64] >> FractionBits);
    end
  end

  always_comb begin
    state_d = state_q;
    neg_d   = neg_q;
    x_d     = x_q;
    y_d     = y_q;
    rem_d   = rem_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    done_d  = 1'b0;
    sum     = '0;
    unique case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          neg_d = req_i.a[63] ^ req_i.b[63];
          x_d   = mag_a;
          y_d   = mag_b;
          acc_d = '0;
          rem_d = '0;
          cnt_d = '0;
          unique case (req_i.op)
            CMD_ADD, CMD_SUB: begin
              sum = (req_i.op == CMD_ADD) ? (req_i.a + req_i.b) : (req_i.a - req_i.b);
              if ((req_i.op == CMD_ADD) ? (req_i.a[63] == req_i.b[63])
                                        : (req_i.a[63] != req_i.b[63])) begin
                if (sum[63] != req_i.a[63])
                  sum = req_i.a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
              end
              res_d  = sum;
              done_d = 1'b1;
            end
            CMD_MUL: state_d = A_MUL;
            default: begin
              // numerator is |a| << FractionBits, fed MSB first
              state_d = A_DIV;
            end
          endcase
        end
      end
      A_MUL: begin
        acc_d = acc_q + (128'(pp) << (32 * (32'(cnt_q[0]) + 32'(cnt_q[1]))));
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(3)) state_d = A_FIN;
      end
      A_DIV: begin
        x_d = {x_q[62:0], 1'b0};
        if (rem_sh >= {1'b0, y_q}) begin
          rem_d = rem_sh - {1'b0, y_q};
          acc_d = {acc_q[126:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          acc_d = {acc_q[126:0], 1'b0};
        end
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(DivSteps - 1)) begin
          // last step; the finish stage reads the quotient from acc_q[63:0]
          state_d = A_FIN;
        end
      end
      A_FIN: begin
        state_d = A_IDLE;
        done_d  = 1'b1;
        if (cnt_q == CntW'(4)) begin
          // product: take bits above the fraction
          if (neg_q) res_d = (ovf_sat || m_sat > 64'h8000_0000_0000_0000)
                             ? 64'h8000_0000_0000_0000 : (~m_sat + 64'd1);
          else       res_d = (ovf_sat || m_sat[63]) ? 64'h7FFF_FFFF_FFFF_FFFF : m_sat;
        end else begin
          // quotient sits in acc_q[63:0], overflow in upper half
          if (neg_q) res_d = ((|acc_q[127:64]) || acc_q[63:0] > 64'h8000_0000_0000_0000)
                             ? 64'h8000_0000_0000_0000 : (~acc_q[63:0] + 64'd1);
          else       res_d = ((|acc_q[127:64]) || acc_q[63])
                             ? 64'h7FFF_FFFF_FFFF_FFFF : acc_q[63:0];
        end
      end
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    x_q   <= x_d;
    y_q   <= y_d;
    rem_q <= rem_d;
    acc_q <= acc_d;
    cnt_q <= cnt_d;
    res_q <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

// ===== hdl/infix_expression_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// infix_expression_evaluator_core : two-stack infix evaluator
// Sequencer with value and operator stacks around a shared arithmetic unit.
// ----------------------------------------------------------------------------
// Usage:
//  tok_i carries pre-lexed tokens (command, number_value); res_o carries one
//  word (result_value, status) per terminator or error. cfg_we_i/cfg_wdata_i
//  write zero_threshold (divisor magnitudes below it count as zero).
//  A number or left bracket passes S_CHECK and S_FIN before ready returns.
//  Each reduction passes S_RDV, S_RDV2, S_ALU and S_WAIT, where multiply
//  runs four 32x32 partial products, one a cycle, and divide one quotient
//  bit a cycle. A token that emits a word also passes S_EMIT. One token is
//  in work at a time; tok_i.ready is low until it is finished.
//  A result waits in an output register; while res_o is stalled the block
//  still takes the next token and stops only when a second result is due.
//  Reset empties both stacks and sets zero_threshold to 429; stack memories
//  are not cleared, entries above the counts are never used.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_core import iee_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  iee_tok_if.sink     tok_i,
  iee_res_if.source   res_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,  // look at operator top
    S_RDV   = 8'b0000_0100,  // read value top
    S_RDV2  = 8'b0000_1000,  // read value below top
    S_ALU   = 8'b0001_0000,
    S_WAIT  = 8'b0010_0000,
    S_FIN   = 8'b0100_0000,  // final action of the token
    S_EMIT  = 8'b1000_0000
  } state_e;

  localparam int unsigned VcW = ValueAw + 1;
  localparam int unsigned OcW = OperatorAw + 1;

  state_e           state_q, state_d;
  logic [63:0]      vmem [ValueDepth];
  logic [2:0]       omem [OperatorDepth];
  logic [VcW-1:0]   vcnt_q, vcnt_d;
  logic [OcW-1:0]   ocnt_q, ocnt_d;
  cmd_e             cmd_q, cmd_d;
  logic [63:0]      num_q, num_d;
  logic [31:0]      thr_q;
  logic [63:0]      b_q, b_d;
  logic [63:0]      vrd_q;
  logic [2:0]       ord_q;
  logic [63:0]      pend_val_q, pend_val_d;  // word waiting for the output
  logic [2:0]       pend_st_q, pend_st_d;
  logic [63:0]      out_val_q, out_val_d;
  logic [2:0]       out_st_q, out_st_d;
  logic             out_vld_q, out_vld_d;
  logic [2:0]       level;

  logic             vwe, owe;
  logic [ValueAw-1:0]    vwa, vra;
  logic [OperatorAw-1:0] owa, ora;
  logic [63:0]      vwd;
  logic [2:0]       owd;

  alu_req_t         areq;
  alu_rsp_t         arsp;
  logic [63:0]      mag_b;

  iee_alu u_alu (.clk_i, .rst_ni, .req_i(areq), .rsp_o(arsp));

  assign tok_i.ready = (state_q == S_IDLE);
  assign res_o.valid        = out_vld_q;
  assign res_o.result_value = out_val_q;
  assign res_o.status       = out_st_q;

  assign level = (cmd_q == CMD_RB || cmd_q == CMD_END) ? 3'(CMD_ADD) : 3'(cmd_q);
  assign mag_b = b_q[63] ? (~b_q + 64'd1) : b_q;

  // sequencer
  always_comb begin
    state_d    = state_q;
    vcnt_d     = vcnt_q;
    ocnt_d     = ocnt_q;
    cmd_d      = cmd_q;
    num_d      = num_q;
    b_d        = b_q;
    pend_val_d = pend_val_q;
    pend_st_d  = pend_st_q;
    out_val_d  = out_val_q;
    out_st_d   = out_st_q;
    out_vld_d  = out_vld_q && !res_o.ready;
    vwe = 1'b0; vwa = vcnt_q[ValueAw-1:0]; vwd = num_q;
    owe = 1'b0; owa = ocnt_q[OperatorAw-1:0]; owd = 3'(cmd_q);
    vra = vcnt_q[ValueAw-1:0] - ValueAw'(1);
    ora = ocnt_q[OperatorAw-1:0] - OperatorAw'(1);
    areq = '{start: 1'b0, op: cmd_e'(ord_q), a: vrd_q, b: b_q};
    unique case (state_q)
      S_IDLE: begin
        if (tok_i.valid && tok_i.ready) begin
          cmd_d   = cmd_e'(tok_i.command);
          num_d   = tok_i.number_value;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        // ord_q holds operator top, read last cycle
        if (cmd_q == CMD_NUM || cmd_q == CMD_LB || ocnt_q == '0 ||
            ord_q == 3'(CMD_LB) || ord_q < level) begin
          state_d = S_FIN;
        end else if (vcnt_q < VcW'(2)) begin
          pend_val_d = '0; pend_st_d = 3'(ST_MISSING); state_d = S_EMIT;
        end else begin
          state_d = S_RDV;
        end
      end
      S_RDV: begin
        // vrd_q now the top value
        b_d     = vrd_q;
        vra     = vcnt_q[ValueAw-1:0] - ValueAw'(2);
        state_d = S_RDV2;
      end
      S_RDV2: begin
        // keep the value below top on the read port for the unit
        vra     = vcnt_q[ValueAw-1:0] - ValueAw'(2);
        state_d = S_ALU;
      end
      S_ALU: begin
        if (ord_q == 3'(CMD_DIV) && (mag_b == '0 || mag_b < {32'd0, thr_q})) begin
          pend_val_d = '0; pend_st_d = 3'(ST_DIV0); state_d = S_EMIT;
        end else begin
          areq.start = 1'b1;
          state_d    = S_WAIT;
        end
      end
      S_WAIT: begin
        if (arsp.done) begin
          vwe    = 1'b1;
          vwa    = vcnt_q[ValueAw-1:0] - ValueAw'(2);
          vwd    = arsp.res;
          vcnt_d = vcnt_q - VcW'(1);
          ocnt_d = ocnt_q - OcW'(1);
          ora    = ocnt_q[OperatorAw-1:0] - OperatorAw'(2);
          vra    = vcnt_q[ValueAw-1:0] - ValueAw'(2);
          state_d = S_CHECK;
        end
      end
      S_FIN: begin
        state_d = S_IDLE;
        unique case (cmd_q)
          CMD_NUM: begin
            if (vcnt_q >= VcW'(ValueDepth)) begin
              pend_val_d = '0; pend_st_d = 3'(ST_OVERFLOW); state_d = S_EMIT;
            end else begin
              vwe = 1'b1; vcnt_d = vcnt_q + VcW'(1);
            end
          end
          CMD_RB: begin
            if (ocnt_q == '0) begin
              pend_val_d = '0; pend_st_d = 3'(ST_UNMATCHED); state_d = S_EMIT;
            end else ocnt_d = ocnt_q - OcW'(1);
          end
          CMD_END: begin
            if (ocnt_q != '0) begin
              pend_val_d = '0; pend_st_d = 3'(ST_UNMATCHED);
            end else if (vcnt_q != VcW'(1)) begin
              pend_val_d = '0; pend_st_d = 3'(ST_NOT_ONE);
            end else begin
              pend_val_d = vrd_q; pend_st_d = 3'(ST_OK);
            end
            state_d = S_EMIT;
          end
          default: begin
            if (ocnt_q >= OcW'(OperatorDepth)) begin
              pend_val_d = '0; pend_st_d = 3'(ST_OVERFLOW); state_d = S_EMIT;
            end else begin
              owe = 1'b1; ocnt_d = ocnt_q + OcW'(1);
            end
          end
        endcase
      end
      S_EMIT: begin
        // wait for the output register to be free
        if (!out_vld_q || res_o.ready) begin
          out_vld_d = 1'b1;
          out_val_d = pend_val_q;
          out_st_d  = pend_st_q;
          vcnt_d    = '0;
          ocnt_d    = '0;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      vcnt_q    <= '0;
      ocnt_q    <= '0;
      out_vld_q <= 1'b0;
      thr_q     <= 32'(ThresholdReset);
    end else begin
      state_q   <= state_d;
      vcnt_q    <= vcnt_d;
      ocnt_q    <= ocnt_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) thr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    num_q      <= num_d;
    b_q        <= b_d;
    pend_val_q <= pend_val_d;
    pend_st_q  <= pend_st_d;
    out_val_q  <= out_val_d;
    out_st_q   <= out_st_d;
  end

  // stack memories, registered read; on the value stack a write to the read address passes through
  always_ff @(posedge clk_i) begin
    if (vwe) vmem[vwa] <= vwd;
    vrd_q <= (vwe && vwa == vra) ? vwd : vmem[vra];
  end

  always_ff @(posedge clk_i) begin
    if (owe) omem[owa] <= owd;
    ord_q <= omem[ora];
  end

endmodule

// ===== hdl/iee_checker.sv =====
// ----------------------------------------------------------------------------
// iee_checker : port-level checks on the evaluator
// Watches the handshakes and result codes seen at the top level.
// ----------------------------------------------------------------------------
module iee_checker import iee_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        tok_valid,
  input logic        tok_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [63:0] res_value,
  input logic [2:0]  res_status
);

  // a held result word keeps its payload
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_value) && $stable(res_status))
    else $error("result word changed while stalled");

  // error words carry zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_status != 3'(ST_OK) |-> res_value == '0)
    else $error("error word with nonzero value");

  // status codes stay in range
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> res_status <= 3'(ST_OVERFLOW))
    else $error("bad status code");

  // a token accepted keeps the block busy the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid && tok_ready |=> !tok_ready)
    else $error("ready right after accepting a token");

endmodule

bind infix_expression_evaluator_core iee_checker u_iee_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .tok_valid  (tok_i.valid),
  .tok_ready  (tok_i.ready),
  .res_valid  (res_o.valid),
  .res_ready  (res_o.ready),
  .res_value  (res_o.result_value),
  .res_status (res_o.status)
);
